>>> hw/rtl/radix2_fft_with_normalization_unit_macros.svh
// Assertion macros used by the checker file
`ifndef RADIX2_FFT_WITH_NORMALIZATION_UNIT_MACROS_SVH
`define RADIX2_FFT_WITH_NORMALIZATION_UNIT_MACROS_SVH
// implication checked every clock, quiet during reset
`define R2F_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
// next-cycle implication
`define R2F_ASSERT_NXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`endif

>>> hw/rtl/r2fft_pkg.sv
// ----------------------------------------------------------------------------
// r2fft_pkg
// Shared constants, types and twiddle functions for the radix-2 FFT unit.
// ----------------------------------------------------------------------------
package r2fft_pkg;
    localparam int MAX_POINTS_DEF   = 64;
    localparam int SAMPLE_BITS_DEF  = 16;
    localparam int TWIDDLE_BITS_DEF = 16;
    localparam int OUT_BITS         = 23;
    localparam int ACC_BITS         = 48;

    localparam logic [1:0] NORM_BACKWARD = 2'd0;
    localparam logic [1:0] NORM_ORTHO    = 2'd1;
    localparam logic [1:0] NORM_FORWARD  = 2'd2;
    localparam logic [1:0] NORM_UNUSED   = 2'd3;

    localparam logic [1:0] REG_LOG2  = 2'd0;
    localparam logic [1:0] REG_INV   = 2'd1;
    localparam logic [1:0] REG_NORM  = 2'd2;

    typedef enum logic [1:0] {
        OP_BFLY  = 2'd0,
        OP_SCALE = 2'd1
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_alu_ctl;

    function automatic logic [31:0] quarter_cos(input logic [4:0] r);
        logic [31:0] v;
        case (r)
            5'd0: v = 32'd1073741824;  5'd1: v = 32'd1068571464;
            5'd2: v = 32'd1053110176;  5'd3: v = 32'd1027506862;
            5'd4: v = 32'd992008094;   5'd5: v = 32'd946955747;
            5'd6: v = 32'd892783698;   5'd7: v = 32'd830013654;
            5'd8: v = 32'd759250125;   5'd9: v = 32'd681174602;
            5'd10: v = 32'd596538995;  5'd11: v = 32'd506158392;
            5'd12: v = 32'd410903207;  5'd13: v = 32'd311690799;
            5'd14: v = 32'd209476638;  5'd15: v = 32'd105245103;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // quarter-wave entry rounded half up to frac bits, signed 33-bit result
    function automatic logic signed [32:0] qc_round(input logic [4:0] r, input int frac);
        logic [32:0] t;
        t = {1'b0, quarter_cos(r)};
        if (frac < 30) t = (t + (33'd1 << (29 - frac))) >> (30 - frac);
        return $signed(t);
    endfunction

    // cos(pi*e/32) in frac fraction bits
    function automatic logic signed [32:0] tw_cos(input logic [5:0] e, input int frac);
        logic [1:0] q;
        logic [4:0] r;
        logic signed [32:0] v;
        q = e[5:4];
        r = {1'b0, e[3:0]};
        case (q)
            2'd0: v = qc_round(r, frac);
            2'd1: v = -qc_round(5'd16 - r, frac);
            2'd2: v = -qc_round(r, frac);
            default: v = qc_round(5'd16 - r, frac);
        endcase
        return v;
    endfunction
endpackage

>>> hw/rtl/r2fft_alu.sv
// ----------------------------------------------------------------------------
// r2fft_alu
// Shared complex multiply unit: butterfly product or output scaling.
// Four products on a single multiplier; o_done pulses as both results are registered.
// ----------------------------------------------------------------------------
module r2fft_alu #(
    parameter int SAMPLE_BITS  = r2fft_pkg::SAMPLE_BITS_DEF,
    parameter int TWIDDLE_BITS = r2fft_pkg::TWIDDLE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  r2fft_pkg::t_alu_ctl          i_ctl,
    input  logic signed [r2fft_pkg::ACC_BITS-1:0] i_vr,
    input  logic signed [r2fft_pkg::ACC_BITS-1:0] i_vi,
    input  logic signed [32:0]           i_wr,
    input  logic signed [32:0]           i_wi,
    input  logic [5:0]                   i_shift,
    output logic                         o_done,
    output logic signed [r2fft_pkg::ACC_BITS-1:0] o_pr,
    output logic signed [r2fft_pkg::ACC_BITS-1:0] o_pi
);
    import r2fft_pkg::*;
    localparam int FR = TWIDDLE_BITS - 2;
    localparam int PW = ACC_BITS + 33;
    // data grow by at most one bit per stage over six stages
    localparam int MX = SAMPLE_BITS + 8;

    logic [2:0]            r_cnt;
    t_op                   r_op;
    logic signed [PW-1:0]  r_acc_r, r_acc_i, r_prod;
    logic signed [ACC_BITS-1:0] a_x;
    logic signed [32:0]    a_w;
    logic signed [MX-1:0]  w_mx;
    logic signed [TWIDDLE_BITS-1:0] w_mw;
    logic signed [MX+TWIDDLE_BITS-1:0] w_prod;
    logic signed [PW-1:0]  w_half_r, w_half_i;
    logic [5:0]            w_sh;

    // operand schedule: vr*wr, vi*wi, vr*wi, vi*wr
    always_comb begin
        case (r_cnt)
            3'd1: begin a_x = i_vr; a_w = i_wr; end
            3'd2: begin a_x = i_vi; a_w = i_wi; end
            3'd3: begin a_x = i_vr; a_w = i_wi; end
            default: begin a_x = i_vi; a_w = i_wr; end
        endcase
    end

    assign w_mx   = $signed(a_x[MX-1:0]);
    assign w_mw   = $signed(a_w[TWIDDLE_BITS-1:0]);
    assign w_prod = w_mx * w_mw;

    assign w_sh = (r_op == OP_BFLY) ? 6'(FR) : i_shift;
    always_comb begin
        w_half_r = (w_sh == 6'd0) ? '0 : (PW'(1) <<< (w_sh - 6'd1));
        w_half_i = w_half_r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 3'd0;
            o_done <= 1'b0;
            r_op   <= OP_BFLY;
        end else begin
            o_done <= 1'b0;
            if (i_ctl.start) begin
                r_cnt   <= 3'd1;
                r_op    <= i_ctl.op;
                r_acc_r <= '0;
                r_acc_i <= '0;
            end else if (r_cnt != 3'd0) begin
                r_prod <= PW'(w_prod);
                r_cnt  <= (r_cnt == 3'd5) ? 3'd0 : r_cnt + 3'd1;
                case (r_cnt)
                    3'd2: r_acc_r <= r_prod;
                    3'd3: r_acc_r <= r_acc_r - r_prod;
                    3'd4: r_acc_i <= r_prod;
                    3'd5: begin
                        o_pr   <= ACC_BITS'((r_acc_r + w_half_r) >>> w_sh);
                        o_pi   <= ACC_BITS'((r_acc_i + r_prod + w_half_i) >>> w_sh);
                        o_done <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end
endmodule

>>> hw/rtl/radix2_fft_with_normalization_unit.sv
// ----------------------------------------------------------------------------
// radix2_fft_with_normalization_unit
// In-place radix-2 DIT FFT with selectable normalization.
// ----------------------------------------------------------------------------
// Usage: write log2_points, inverse_mode and norm_mode through the write
// port while idle. Present samples with start; a beat is taken when
// start is high and busy is low. After the last sample of a frame of
// N = 2^L points the block goes busy: per butterfly it reads the two
// words, forms the operands, runs four products, final sum and handoff
// on the single shared multiplier and writes the two results back; then
// each bin is read, scaled on the same multiplier and driven for one
// cycle with o_valid; each bin is out before the read of another starts.
// The receiver cannot stall: o_valid marks each bin for one cycle.
// Reset clears the registers to L = 6, forward, backward normalization
// and discards any partial frame. Writing log2_points drops the partial
// frame as well. L = 0 returns each sample as its own bin.
// ----------------------------------------------------------------------------
module radix2_fft_with_normalization_unit #(
    parameter int MAX_POINTS   = r2fft_pkg::MAX_POINTS_DEF,
    parameter int SAMPLE_BITS  = r2fft_pkg::SAMPLE_BITS_DEF,
    parameter int TWIDDLE_BITS = r2fft_pkg::TWIDDLE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_idx,
    input  logic [2:0]              i_cfg_data,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_real,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_imag,
    output logic                    o_valid,
    output logic signed [r2fft_pkg::OUT_BITS-1:0] o_bin_real,
    output logic signed [r2fft_pkg::OUT_BITS-1:0] o_bin_imag,
    output logic [5:0]              o_bin_index,
    output logic                    o_last_bin
);
    import r2fft_pkg::*;
    localparam int FR   = TWIDDLE_BITS - 2;
    localparam int MAXL = (MAX_POINTS >= 64) ? 6 : $clog2(MAX_POINTS + 1) - 1;
    localparam int AW   = 6;
    localparam int DW   = 2 * ACC_BITS;

    typedef enum logic [3:0] {
        S_LOAD, S_RD_U, S_RD_V, S_MUL, S_WAIT, S_WR_U, S_WR_V,
        S_ORD, S_OWAIT_RD, S_OMUL, S_OWAIT
    } t_state;

    t_state      r_state;
    logic [2:0]  r_log2;
    logic        r_inv;
    logic [1:0]  r_norm;
    logic [6:0]  r_load_cnt;
    logic [2:0]  r_stage;
    logic [5:0]  r_bfly;
    logic [6:0]  r_out_k;
    logic [DW-1:0] r_mem [0:63];
    logic [DW-1:0] r_rd;
    logic signed [ACC_BITS-1:0] r_ur, r_ui, r_vr, r_vi;
    logic signed [32:0] r_wr, r_wi;
    logic [5:0]  r_shift;
    t_alu_ctl    w_ctl;
    logic        w_done;
    logic signed [ACC_BITS-1:0] w_pr, w_pi;
    logic [2:0]  w_l;
    logic [6:0]  w_n;
    logic [5:0]  w_h, w_k, w_iu, w_iv, w_m, w_e, w_brev, w_lc;
    logic [AW-1:0] w_raddr;
    logic        w_mem_we;
    logic [AW-1:0] w_waddr;
    logic [DW-1:0] w_wdata;
    logic signed [ACC_BITS-1:0] w_sr, w_si;
    logic signed [32:0] w_isq;
    logic signed [ACC_BITS-1:0] w_hi, w_lo;

    assign w_l  = (r_log2 > 3'(MAXL)) ? 3'(MAXL) : r_log2;
    assign w_n  = 7'd1 << w_l;
    assign w_h  = 6'(7'd1 << r_stage);
    assign w_k  = r_bfly & (w_h - 6'd1);
    assign w_iu = ((r_bfly & ~(w_h - 6'd1)) << 1) | w_k;
    assign w_iv = w_iu | w_h;
    assign w_m  = 6'((w_k << (3'd5 - r_stage)));
    assign w_e  = r_inv ? w_m : 6'(6'd0 - w_m);
    assign w_lc = r_load_cnt[5:0];
    assign w_isq = tw_cos(6'd8, FR);

    // bit-reverse the load address over L bits so the store is permuted on entry
    always_comb begin
        w_brev = '0;
        for (int b = 0; b < 6; b++)
            if (b < int'(w_l)) w_brev[int'(w_l) - 1 - b] = w_lc[b];
    end

    assign w_hi = ACC_BITS'((1 <<< (OUT_BITS - 1)) - 1);
    assign w_lo = -w_hi - ACC_BITS'(1);

    function automatic logic signed [OUT_BITS-1:0] sat(input logic signed [ACC_BITS-1:0] x,
                                                      input logic signed [ACC_BITS-1:0] hi,
                                                      input logic signed [ACC_BITS-1:0] lo);
        logic signed [ACC_BITS-1:0] t;
        t = (x > hi) ? hi : ((x < lo) ? lo : x);
        return OUT_BITS'(t);
    endfunction

    always_comb begin
        w_sr = r_ur + w_pr;
        w_si = r_ui + w_pi;
        w_raddr  = w_iu;
        w_mem_we = 1'b0;
        w_waddr  = w_iu;
        w_wdata  = {w_sr, w_si};
        unique case (r_state)
            S_LOAD: begin
                w_mem_we = start && !busy;
                w_waddr  = w_brev;
                w_wdata  = {ACC_BITS'(i_sample_real), ACC_BITS'(i_sample_imag)};
            end
            S_RD_V: w_raddr = w_iv;
            S_WR_U: w_mem_we = 1'b1;
            S_WR_V: begin
                w_mem_we = 1'b1;
                w_waddr  = w_iv;
                w_wdata  = {r_ur - r_vr, r_ui - r_vi};
            end
            // hold the bin address until its word is taken
            S_ORD, S_OWAIT_RD: w_raddr = r_out_k[5:0];
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_mem[w_waddr] <= w_wdata;
        r_rd <= r_mem[w_raddr];
    end

    assign busy = (r_state != S_LOAD);

    always_comb begin
        w_ctl.start = (r_state == S_MUL) || (r_state == S_OMUL);
        w_ctl.op    = (r_state == S_OMUL) ? OP_SCALE : OP_BFLY;
    end

    r2fft_alu #(.SAMPLE_BITS(SAMPLE_BITS), .TWIDDLE_BITS(TWIDDLE_BITS)) u_alu (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl),
        .i_vr(r_vr), .i_vi(r_vi), .i_wr(r_wr), .i_wi(r_wi),
        .i_shift(r_shift), .o_done(w_done), .o_pr(w_pr), .o_pi(w_pi)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_log2     <= 3'd6;
            r_inv      <= 1'b0;
            r_norm     <= NORM_BACKWARD;
            r_load_cnt <= '0;
            r_stage    <= '0;
            r_bfly     <= '0;
            r_out_k    <= '0;
            o_valid    <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_LOG2: begin r_log2 <= i_cfg_data; r_load_cnt <= '0; end
                    REG_INV:  r_inv  <= i_cfg_data[0];
                    REG_NORM: r_norm <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_LOAD: if (start) begin
                    if (r_load_cnt + 7'd1 >= w_n) begin
                        r_load_cnt <= '0;
                        r_stage    <= '0;
                        r_bfly     <= '0;
                        r_out_k    <= '0;
                        r_state    <= (w_l == 3'd0) ? S_ORD : S_RD_U;
                    end else begin
                        r_load_cnt <= r_load_cnt + 7'd1;
                    end
                end
                S_RD_U: r_state <= S_RD_V;
                S_RD_V: begin
                    r_ur <= r_rd[DW-1:ACC_BITS];
                    r_ui <= r_rd[ACC_BITS-1:0];
                    r_wr <= tw_cos(w_e, FR);
                    r_wi <= tw_cos(6'(w_e - 6'd16), FR);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_vr <= r_rd[DW-1:ACC_BITS];
                    r_vi <= r_rd[ACC_BITS-1:0];
                    r_state <= S_WAIT;
                end
                S_WAIT: if (w_done) begin
                    r_vr <= w_pr;
                    r_vi <= w_pi;
                    r_state <= S_WR_U;
                end
                S_WR_U: r_state <= S_WR_V;
                S_WR_V: begin
                    if (7'(r_bfly) + 7'd1 >= (w_n >> 1)) begin
                        r_bfly <= '0;
                        if (r_stage + 3'd1 >= w_l) r_state <= S_ORD;
                        else begin
                            r_stage <= r_stage + 3'd1;
                            r_state <= S_RD_U;
                        end
                    end else begin
                        r_bfly  <= r_bfly + 6'd1;
                        r_state <= S_RD_U;
                    end
                end
                S_ORD: begin
                    r_wi <= '0;
                    r_wr <= 33'sd1 <<< FR;
                    r_shift <= 6'(FR);
                    case (r_norm)
                        NORM_ORTHO: begin
                            r_shift <= 6'(FR) + 6'(w_l >> 1);
                            if (w_l[0]) r_wr <= w_isq;
                        end
                        NORM_FORWARD: if (!r_inv) r_shift <= 6'(FR) + 6'(w_l);
                        default: if (r_inv) r_shift <= 6'(FR) + 6'(w_l);
                    endcase
                    r_state <= S_OWAIT_RD;
                end
                S_OWAIT_RD: r_state <= S_OMUL;
                S_OMUL: begin
                    r_vr <= r_rd[DW-1:ACC_BITS];
                    r_vi <= r_rd[ACC_BITS-1:0];
                    r_state <= S_OWAIT;
                end
                S_OWAIT: if (w_done) begin
                    o_valid     <= 1'b1;
                    o_bin_real  <= sat(w_pr, w_hi, w_lo);
                    o_bin_imag  <= sat(w_pi, w_hi, w_lo);
                    o_bin_index <= r_out_k[5:0];
                    o_last_bin  <= (r_out_k + 7'd1 == w_n);
                    if (r_out_k + 7'd1 >= w_n) r_state <= S_LOAD;
                    else begin
                        r_out_k <= r_out_k + 7'd1;
                        r_state <= S_ORD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end
endmodule

>>> hw/rtl/r2fft_checker.sv
// ----------------------------------------------------------------------------
// r2fft_checker
// Port-level checks on the FFT unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "radix2_fft_with_normalization_unit_macros.svh"
module r2fft_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       busy,
    input logic       o_valid,
    input logic       o_last_bin
);
    `R2F_ASSERT_IMP(a_valid_busy, i_clk, i_rst_n, o_valid, busy || o_last_bin, "bin while idle")
    `R2F_ASSERT_IMP(a_last_idle, i_clk, i_rst_n, o_valid && o_last_bin, !busy, "busy at last")
    `R2F_ASSERT_NXT(a_no_dbl, i_clk, i_rst_n, o_valid, !o_valid, "back-to-back bins")
    `R2F_ASSERT_IMP(a_idle_last, i_clk, i_rst_n, $fell(busy), o_valid && o_last_bin,
        "idle without last bin")
endmodule

bind radix2_fft_with_normalization_unit r2fft_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .busy(busy), .o_valid(o_valid),
    .o_last_bin(o_last_bin)
);

>>> tb/tb_radix2_fft_with_normalization_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radix2_fft_with_normalization_unit
// Loads frames of complex samples under varied lengths, both directions and every scaling
// mode, predicts every bin with an integer FFT model and checks the bins in
// order as they leave the unit.
// ----------------------------------------------------------------------------
module tb_radix2_fft_with_normalization_unit;
    import r2fft_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_idx;
    logic [2:0]         i_cfg_data;
    logic signed [15:0] i_sample_real;
    logic signed [15:0] i_sample_imag;
    logic               o_valid;
    logic signed [22:0] o_bin_real;
    logic signed [22:0] o_bin_imag;
    logic [5:0]         o_bin_index;
    logic               o_last_bin;

    typedef struct packed {
        logic signed [22:0] re;
        logic signed [22:0] im;
        logic [5:0]         idx;
        logic               last;
    } t_bin;

    localparam int TWF = 14;

    t_bin          bin_queue[$];
    int            err_count;
    int            bin_count;
    int            frame_count;
    logic [2:0]    cur_log2;
    logic          cur_inv;
    logic [1:0]    cur_norm;
    longint        frame_re[64];
    longint        frame_im[64];
    int            fill;

    radix2_fft_with_normalization_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_sample_real(i_sample_real), .i_sample_imag(i_sample_imag),
        .o_valid(o_valid), .o_bin_real(o_bin_real), .o_bin_imag(o_bin_imag),
        .o_bin_index(o_bin_index), .o_last_bin(o_last_bin)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #400ms;
        $display("tb_radix2_fft_with_normalization_unit: done, errors");
        $finish;
    end

    function automatic longint rnd_shift(longint x, int s);
        if (s <= 0) return x;
        return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint twid_cos(int e);
        int q;
        int r;
        longint v;
        q = (e >> 4) & 3;
        r = e & 15;
        case (q)
            0: v = longint'(quarter_cos(5'(r)));
            1: v = -longint'(quarter_cos(5'(16 - r)));
            2: v = -longint'(quarter_cos(5'(r)));
            default: v = longint'(quarter_cos(5'(16 - r)));
        endcase
        return rnd_shift(v, 30 - TWF);
    endfunction

    function automatic logic signed [22:0] clamp23(longint x);
        if (x > 4194303) return 23'sd4194303;
        if (x < -4194304) return $signed(23'h400000);
        return x[22:0];
    endfunction

    // run the transform on a full frame and queue its bins
    task automatic predict_frame(int lg);
        longint ar[64];
        longint ai[64];
        longint wr, wi, pr, pi, ur, ui, mul;
        int n, j, stp, m, e, s;
        n = 1 << lg;
        for (int i = 0; i < n; i++) begin
            j = 0;
            for (int b = 0; b < lg; b++) if ((i >> b) & 1) j |= 1 << (lg - 1 - b);
            ar[j] = frame_re[i];
            ai[j] = frame_im[i];
        end
        for (int h = 1; h < n; h <<= 1) begin
            stp = 32 / h;
            for (int i = 0; i < n; i += 2 * h) begin
                for (int k = 0; k < h; k++) begin
                    m = (k * stp) & 63;
                    e = cur_inv ? m : ((64 - m) & 63);
                    wr = twid_cos(e);
                    wi = twid_cos((e - 16) & 63);
                    pr = rnd_shift(ar[i+k+h] * wr - ai[i+k+h] * wi, TWF);
                    pi = rnd_shift(ar[i+k+h] * wi + ai[i+k+h] * wr, TWF);
                    ur = ar[i+k];
                    ui = ai[i+k];
                    ar[i+k] = ur + pr;  ai[i+k] = ui + pi;
                    ar[i+k+h] = ur - pr; ai[i+k+h] = ui - pi;
                end
            end
        end
        mul = longint'(1) << TWF;
        if (cur_norm == NORM_ORTHO) begin
            s = lg / 2;
            if (lg & 1) mul = rnd_shift(longint'(quarter_cos(5'd8)), 30 - TWF);
        end else if (cur_norm == NORM_FORWARD) begin
            s = cur_inv ? 0 : lg;
        end else begin
            s = cur_inv ? lg : 0;
        end
        for (int k = 0; k < n; k++) begin
            t_bin b;
            b.re = clamp23(rnd_shift(ar[k] * mul, TWF + s));
            b.im = clamp23(rnd_shift(ai[k] * mul, TWF + s));
            b.idx = k[5:0];
            b.last = (k == n - 1);
            bin_queue = {bin_queue, b};
        end
    endtask

    // check each bin as it goes by
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            t_bin want;
            if (bin_queue.size() == 0) begin
                $display("%0t: unexpected bin re=%0d im=%0d idx=%0d", $time,
                         o_bin_real, o_bin_imag, o_bin_index);
                err_count++;
            end else begin
                want = bin_queue.pop_front();
                bin_count++;
                if (want.re !== o_bin_real || want.im !== o_bin_imag
                    || want.idx !== o_bin_index || want.last !== o_last_bin) begin
                    $display("%0t: bin mismatch expected re=%0d im=%0d idx=%0d last=%0b",
                             $time, want.re, want.im, want.idx, want.last);
                    $display("%0t:              actual re=%0d im=%0d idx=%0d last=%0b",
                             $time, o_bin_real, o_bin_imag, o_bin_index, o_last_bin);
                    err_count++;
                end
            end
        end
    end

    // leaves the write enable high; the next sample or drain drops it
    task automatic write_reg(logic [1:0] idx, logic [2:0] val);
        start      <= 1'b0;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        if (idx == REG_LOG2) begin
            cur_log2 = val;
            fill = 0;
        end else if (idx == REG_INV) begin
            cur_inv = val[0];
        end else begin
            cur_norm = (val[1:0] == NORM_UNUSED) ? NORM_BACKWARD : val[1:0];
        end
    endtask

    // wait for all bins, then let the unit settle before touching registers
    task automatic drain();
        int guard;
        guard = 0;
        start    <= 1'b0;
        i_cfg_we <= 1'b0;
        while (bin_queue.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
    endtask

    task automatic configure(logic [2:0] lg, logic inv, logic [1:0] nm);
        drain();
        write_reg(REG_LOG2, lg);
        write_reg(REG_INV, {2'b0, inv});
        write_reg(REG_NORM, {1'b0, nm});
    endtask

    // send one sample beat, now and then after a gap with start low; else start stays high between beats
    task automatic send_sample(logic signed [15:0] re, logic signed [15:0] im);
        int lg;
        i_cfg_we <= 1'b0;
        if ($urandom_range(0, 5) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_sample_real <= re;
        i_sample_imag <= im;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        lg = (cur_log2 > 6) ? 6 : cur_log2;
        frame_re[fill] = re;
        frame_im[fill] = im;
        fill++;
        if (fill == (1 << lg)) begin
            predict_frame(lg);
            frame_count++;
            fill = 0;
        end
    endtask

    task automatic test_directed();
        // extremes at L=2, then single-point frames, an L=3 frame and an L=1 frame in the unused mode
        configure(3'd2, 1'b0, NORM_BACKWARD);
        send_sample(16'sh7fff, 16'sh8000);
        send_sample(16'sh8000, 16'sh7fff);
        send_sample(16'sh7fff, 16'sh7fff);
        send_sample(16'sh8000, 16'sh8000);
        configure(3'd0, 1'b1, NORM_ORTHO);
        send_sample(16'sh8000, 16'sh7fff);
        send_sample(16'sh0000, 16'shffff);
        configure(3'd3, 1'b1, NORM_ORTHO);
        for (int i = 0; i < 8; i++) send_sample(16'sh8000, 16'sh8000);
        configure(3'd1, 1'b0, NORM_UNUSED);
        send_sample(16'sh7fff, 16'sh0001);
        send_sample(16'sh8000, 16'sh0000);
    endtask

    task automatic test_partial_discard();
        configure(3'd2, 1'b0, NORM_FORWARD);
        send_sample(16'sh1234, 16'sh4321);
        send_sample(16'shedcb, 16'sh0100);
        // rewriting the length drops the two loaded samples
        write_reg(REG_LOG2, 3'd2);
        for (int i = 0; i < 4; i++) send_sample(16'($urandom), 16'($urandom));
    endtask

    task automatic test_oversize();
        configure(3'd7, 1'b0, NORM_FORWARD);
        for (int i = 0; i < 64; i++) send_sample(16'($urandom), 16'($urandom));
    endtask

    task automatic test_random();
        int sent;
        logic [2:0] lg;
        sent = 0;
        while (sent < 16) begin
            lg = 3'($urandom_range(0, 5));
            configure(lg, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
            for (int i = 0; i < (1 << lg); i++) begin
                send_sample(16'($urandom), 16'($urandom));
                sent++;
            end
        end
        configure(3'd6, 1'b1, NORM_FORWARD);
        for (int i = 0; i < 64; i++) send_sample(16'($urandom), 16'($urandom));
    endtask

    initial begin
        err_count = 0; bin_count = 0; frame_count = 0; fill = 0;
        cur_log2 = 3'd6; cur_inv = 1'b0; cur_norm = NORM_BACKWARD;
        i_rst_n = 1'b0; start = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = REG_LOG2;
        i_cfg_data = 3'd0; i_sample_real = 16'sd0; i_sample_imag = 16'sd0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_partial_discard();
        test_oversize();
        test_random();
        drain();
        repeat (200) @(posedge i_clk);
        $display("covered %0d frames, %0d bins over lengths 1..64, both directions,",
                 frame_count, bin_count);
        $display("all scaling modes and the unused mode code");
        if (err_count == 0 && bin_queue.size() == 0) begin
            $display("tb_radix2_fft_with_normalization_unit: done, clean");
        end else begin
            $display("tb_radix2_fft_with_normalization_unit: done, errors");
        end
        $finish;
    end
endmodule
